// ===== design/priority_queue_sorted_insert_defines.svh =====
// assertion macros for the sorted priority queue checker
`ifndef PRIORITY_QUEUE_SORTED_INSERT_DEFINES_SVH
`define PRIORITY_QUEUE_SORTED_INSERT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define PQSI_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define PQSI_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/pqsi_pkg.sv =====
// shared types, codes and defaults for the sorted priority queue
package pqsi_pkg;

  localparam int DEPTH_DEFAULT         = 16;
  localparam int PRIO_WIDTH_DEFAULT    = 8;
  localparam int PAYLOAD_WIDTH_DEFAULT = 32;

  // fixed field widths of the request and response transactions
  localparam int PRIO_W = 8;
  localparam int PAY_W  = 32;
  localparam int OCC_W  = 5;
  localparam int STAT_W = 2;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_POP    = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic              req_type;
    logic [PRIO_W-1:0] job_prio;
    logic [PAY_W-1:0]  job_payload;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              out_valid;
    logic [PRIO_W-1:0] out_prio;
    logic [PAY_W-1:0]  out_payload;
    logic [OCC_W-1:0]  occupancy;
  } rsp_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;
    logic pop;
  } cell_ctl_t;

endpackage

// ===== design/pqsi_cell.sv =====
// one slot of the sorted store: holds a job and shifts with its neighbors
module pqsi_cell #(
  parameter int PRIO_WIDTH    = pqsi_pkg::PRIO_WIDTH_DEFAULT,
  parameter int PAYLOAD_WIDTH = pqsi_pkg::PAYLOAD_WIDTH_DEFAULT
) (
  input  logic                     clk,
  input  pqsi_pkg::cell_ctl_t      ctl,
  input  logic                     occupied,
  input  logic [PRIO_WIDTH-1:0]    new_prio,
  input  logic [PAYLOAD_WIDTH-1:0] new_payload,
  input  logic                     left_lower,
  input  logic [PRIO_WIDTH-1:0]    left_prio,
  input  logic [PAYLOAD_WIDTH-1:0] left_payload,
  input  logic [PRIO_WIDTH-1:0]    right_prio,
  input  logic [PAYLOAD_WIDTH-1:0] right_payload,
  output logic                     lower,
  output logic [PRIO_WIDTH-1:0]    prio,
  output logic [PAYLOAD_WIDTH-1:0] payload
);
  import pqsi_pkg::*;

  // empty slot or strictly lower priority: new job goes at or before here
  assign lower = !occupied || (prio < new_prio);

  always_ff @(posedge clk) begin
    if (ctl.ins && lower) begin
      if (left_lower) begin
        prio    <= left_prio;
        payload <= left_payload;
      end else begin
        prio    <= new_prio;
        payload <= new_payload;
      end
    end else if (ctl.pop) begin
      prio    <= right_prio;
      payload <= right_payload;
    end
  end

endmodule

// ===== design/priority_queue_sorted_insert.sv =====
// top level: sorted job priority queue built as a row of shifting cells
//
//   channel   | handshake        | payload
//   ----------+------------------+---------------------------
//   request   | start / busy     | req  (req_type, job_prio, job_payload)
//   response  | done (strobe)    | rsp  (status, out_valid, out_prio,
//             |                  |       out_payload, occupancy)
//
// every request is handled without stalling: all cells compare against the new job in
// parallel and shift in the same clock, so busy stays low
// the response appears in the cycle after the request, for one cycle
// synchronous reset empties the queue; slot contents are not cleared
// the response cannot be stalled; a request may follow every cycle
module priority_queue_sorted_insert #(
  parameter int DEPTH         = pqsi_pkg::DEPTH_DEFAULT,
  parameter int PRIO_WIDTH    = pqsi_pkg::PRIO_WIDTH_DEFAULT,
  parameter int PAYLOAD_WIDTH = pqsi_pkg::PAYLOAD_WIDTH_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  pqsi_pkg::req_t req,
  output logic           done,
  output pqsi_pkg::rsp_t rsp
);
  import pqsi_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  logic [CW-1:0]            count;
  logic [CW-1:0]            count_next;
  logic                     accept;
  logic                     is_full;
  logic                     is_empty;
  cell_ctl_t                ctl;
  logic [PRIO_WIDTH-1:0]    new_prio;
  logic [PAYLOAD_WIDTH-1:0] new_payload;

  logic                     lower_a   [DEPTH];
  logic [PRIO_WIDTH-1:0]    prio_a    [DEPTH];
  logic [PAYLOAD_WIDTH-1:0] payload_a [DEPTH];

  assign busy        = 1'b0;
  assign accept      = start && !busy;
  assign is_full     = (count == FULL_COUNT);
  assign is_empty    = (count == '0);
  assign new_prio    = PRIO_WIDTH'(req.job_prio);
  assign new_payload = PAYLOAD_WIDTH'(req.job_payload);

  assign ctl.ins = accept && (req.req_type == REQ_INSERT) && !is_full;
  assign ctl.pop = accept && (req.req_type == REQ_POP) && !is_empty;

  always_comb begin
    count_next = count;
    if (ctl.ins) begin
      count_next = count + CW'(1);
    end else if (ctl.pop) begin
      count_next = count - CW'(1);
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                     l_lower;
    logic [PRIO_WIDTH-1:0]    l_prio;
    logic [PAYLOAD_WIDTH-1:0] l_payload;
    logic [PRIO_WIDTH-1:0]    r_prio;
    logic [PAYLOAD_WIDTH-1:0] r_payload;

    if (i == 0) begin : g_head
      assign l_lower   = 1'b0;
      assign l_prio    = '0;
      assign l_payload = '0;
    end else begin : g_mid
      assign l_lower   = lower_a[i-1];
      assign l_prio    = prio_a[i-1];
      assign l_payload = payload_a[i-1];
    end

    // the tail pulls in don't-care data on a pop; it falls out of range
    if (i == DEPTH - 1) begin : g_tail
      assign r_prio    = '0;
      assign r_payload = '0;
    end else begin : g_body
      assign r_prio    = prio_a[i+1];
      assign r_payload = payload_a[i+1];
    end

    pqsi_cell #(
      .PRIO_WIDTH    (PRIO_WIDTH),
      .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
    ) u_cell (
      .clk           (clk),
      .ctl           (ctl),
      .occupied      (count > CW'(i)),
      .new_prio      (new_prio),
      .new_payload   (new_payload),
      .left_lower    (l_lower),
      .left_prio     (l_prio),
      .left_payload  (l_payload),
      .right_prio    (r_prio),
      .right_payload (r_payload),
      .lower         (lower_a[i]),
      .prio          (prio_a[i]),
      .payload       (payload_a[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= accept;
    end
  end

  // response payload, taken from the head before it shifts out
  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.status      <= ST_OK;
      rsp.out_valid   <= 1'b0;
      rsp.out_prio    <= '0;
      rsp.out_payload <= '0;
      rsp.occupancy   <= OCC_W'(count_next);
      if (req.req_type == REQ_INSERT) begin
        if (is_full) begin
          rsp.status <= ST_FULL;
        end
      end else if (is_empty) begin
        rsp.status <= ST_EMPTY;
      end else begin
        rsp.out_valid   <= 1'b1;
        rsp.out_prio    <= PRIO_W'(prio_a[0]);
        rsp.out_payload <= PAY_W'(payload_a[0]);
      end
    end
  end

endmodule

// ===== design/pqsi_checker.sv =====
// port-level checks for the sorted priority queue, bound to the top level
`include "priority_queue_sorted_insert_defines.svh"

module pqsi_checker (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input pqsi_pkg::req_t req,
  input logic           done,
  input pqsi_pkg::rsp_t rsp
);
  import pqsi_pkg::*;

  `PQSI_ASSERT_NEXT(a_resp_follows, clk, rst, start && !busy, done, "accepted transaction gave no response")
  `PQSI_ASSERT_NEXT(a_no_spurious, clk, rst, !(start && !busy), !done, "response without a transaction")
  `PQSI_ASSERT_NOW(a_valid_ok, clk, rst, done && rsp.out_valid, rsp.status == ST_OK, "returned job with error status")
  `PQSI_ASSERT_NOW(a_zero_fill, clk, rst, done && !rsp.out_valid, rsp.out_prio == '0 && rsp.out_payload == '0, "nonzero job fields without a returned job")
  `PQSI_ASSERT_NOW(a_pop_ok_valid, clk, rst, done && $past(req.req_type == REQ_POP) && rsp.status == ST_OK, rsp.out_valid, "successful pop returned no job")

endmodule

bind priority_queue_sorted_insert pqsi_checker u_pqsi_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .req   (req),
  .done  (done),
  .rsp   (rsp)
);

// ===== tb/priority_queue_sorted_insert_checker.sv =====
// checker for the sorted priority queue: predicts every response and compares it
`timescale 1ns / 1ps

module priority_queue_sorted_insert_checker #(
  parameter int DEPTH = pqsi_pkg::DEPTH_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic           busy,
  input  pqsi_pkg::req_t req,
  input  logic           done,
  input  pqsi_pkg::rsp_t rsp,
  output int             errors,
  output int             awaited
);
  import pqsi_pkg::*;

  // predicted job store, slot 0 is the head
  logic [PRIO_W-1:0] sorted_prio    [DEPTH];
  logic [PAY_W-1:0]  sorted_payload [DEPTH];
  int                stored_jobs;
  rsp_t              queued_replies [$];

  initial begin
    errors      = 0;
    stored_jobs = 0;
  end

  assign awaited = queued_replies.size();

  function automatic rsp_t apply_request(input req_t r);
    rsp_t reply;
    int   pos;
    int   i;
    reply = '0;
    if (r.req_type == REQ_INSERT) begin
      if (stored_jobs >= DEPTH) begin
        reply.status = ST_FULL;
      end else begin
        // new job goes behind every job of equal or higher priority
        pos = stored_jobs;
        for (i = 0; i < stored_jobs; i++) begin
          if (sorted_prio[i] < r.job_prio) begin
            pos = i;
            break;
          end
        end
        for (i = stored_jobs; i > pos; i--) begin
          sorted_prio[i]    = sorted_prio[i-1];
          sorted_payload[i] = sorted_payload[i-1];
        end
        sorted_prio[pos]    = r.job_prio;
        sorted_payload[pos] = r.job_payload;
        stored_jobs++;
        reply.status = ST_OK;
      end
    end else begin
      if (stored_jobs == 0) begin
        reply.status = ST_EMPTY;
      end else begin
        reply.status      = ST_OK;
        reply.out_valid   = 1'b1;
        reply.out_prio    = sorted_prio[0];
        reply.out_payload = sorted_payload[0];
        for (i = 1; i < stored_jobs; i++) begin
          sorted_prio[i-1]    = sorted_prio[i];
          sorted_payload[i-1] = sorted_payload[i];
        end
        stored_jobs--;
      end
    end
    reply.occupancy = OCC_W'(stored_jobs);
    return reply;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (!rst) begin
      if (start && !busy) begin
        queued_replies.push_back(apply_request(req));
      end
      if (done) begin
        if (queued_replies.size() == 0) begin
          $error("response transaction with no request outstanding");
          errors++;
        end else begin
          want = queued_replies.pop_front();
          if (rsp.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, rsp.status);
            errors++;
          end
          if (rsp.out_valid !== want.out_valid) begin
            $error("out_valid: expected %0d, actual %0d", want.out_valid, rsp.out_valid);
            errors++;
          end
          if (rsp.out_prio !== want.out_prio) begin
            $error("out_prio: expected %0d, actual %0d", want.out_prio, rsp.out_prio);
            errors++;
          end
          if (rsp.out_payload !== want.out_payload) begin
            $error("out_payload: expected %h, actual %h", want.out_payload, rsp.out_payload);
            errors++;
          end
          if (rsp.occupancy !== want.occupancy) begin
            $error("occupancy: expected %0d, actual %0d", want.occupancy, rsp.occupancy);
            errors++;
          end
        end
      end
    end
  end

endmodule

// ===== tb/tb_priority_queue_sorted_insert.sv =====
// testbench top for the sorted priority queue: request stimulus and verdict
`timescale 1ns / 1ps

module tb_priority_queue_sorted_insert;
  import pqsi_pkg::*;

  localparam int REQUEST_TARGET = 1250;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  req_t req;
  logic done;
  rsp_t rsp;
  int   errors;
  int   awaited;
  logic idle_on;
  int   sent;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  priority_queue_sorted_insert u_dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .req   (req),
    .done  (done),
    .rsp   (rsp)
  );

  priority_queue_sorted_insert_checker #(
    .DEPTH (DEPTH_DEFAULT)
  ) u_checker (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .req     (req),
    .done    (done),
    .rsp     (rsp),
    .errors  (errors),
    .awaited (awaited)
  );

  // one request transaction, with an optional random gap in front
  task automatic send(input logic kind, input logic [PRIO_W-1:0] p,
                      input logic [PAY_W-1:0] d);
    int gap;
    gap = idle_on ? $urandom_range(14, 0) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    req   <= '{req_type: kind, job_prio: p, job_payload: d};
    do @(posedge clk); while (busy);
    sent++;
  endtask

  initial begin
    int burst_len;
    int insert_pct;
    int narrow;
    int n;
    rst     <= 1'b1;
    start   <= 1'b0;
    req     <= '0;
    idle_on  = 1'b0;
    sent     = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // empty pop, then fill with extremes and ties, overflow, drain part way
    send(REQ_POP,    8'd0,   32'h0000_0000);
    send(REQ_INSERT, 8'd100, 32'h0000_0000);
    send(REQ_INSERT, 8'd100, 32'hFFFF_FFFF);
    send(REQ_INSERT, 8'd255, 32'h0000_0001);
    send(REQ_INSERT, 8'd0,   32'h0000_0002);
    send(REQ_INSERT, 8'd255, 32'h0000_0003);
    send(REQ_INSERT, 8'd0,   32'h0000_0004);
    send(REQ_INSERT, 8'd100, 32'hA5A5_5A5A);
    send(REQ_INSERT, 8'd1,   32'h5A5A_A5A5);
    send(REQ_INSERT, 8'd254, 32'h0000_0008);
    send(REQ_INSERT, 8'd128, 32'h8000_0000);
    send(REQ_INSERT, 8'd127, 32'h7FFF_FFFF);
    send(REQ_INSERT, 8'd255, 32'h0000_000B);
    send(REQ_INSERT, 8'd0,   32'h0000_000C);
    send(REQ_INSERT, 8'd100, 32'h0000_000D);
    send(REQ_INSERT, 8'd50,  32'h0000_000E);
    send(REQ_INSERT, 8'd200, 32'h0000_000F);
    send(REQ_INSERT, 8'd255, 32'hFFFF_FFFF);
    send(REQ_INSERT, 8'd0,   32'h0000_0000);
    repeat (6) send(REQ_POP, 8'hFF, 32'hFFFF_FFFF);

    // bursts that lean toward filling or draining, so full and empty recur
    while (sent < REQUEST_TARGET) begin
      burst_len = $urandom_range(60, 20);
      case ($urandom_range(2, 0))
        0:       insert_pct = 25;
        1:       insert_pct = 50;
        default: insert_pct = 80;
      endcase
      narrow  = $urandom_range(1, 0);
      idle_on = 1'($urandom_range(1, 0));
      for (n = 0; n < burst_len; n++) begin
        send(($urandom_range(99, 0) < insert_pct) ? REQ_INSERT : REQ_POP,
             narrow ? PRIO_W'($urandom_range(3, 0)) : PRIO_W'($urandom_range(255, 0)),
             $urandom);
      end
    end
    start <= 1'b0;

    while (awaited != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (errors == 0) begin
      $display("** priority_queue_sorted_insert: PASSED **");
    end else begin
      $display("** priority_queue_sorted_insert: FAILED **");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("** priority_queue_sorted_insert: FAILED **");
    $finish;
  end

endmodule
